### rtl/hcns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcns_pkg
// types, command codes, register indexes and arithmetic helpers of the solver
// ----------------------------------------------------------------------------
package hcns_pkg;

    typedef struct packed {
        logic [1:0] cmd;
        logic [5:0] point_index;
    } hcns_in_t;

    typedef struct packed {
        logic [15:0]        step_count;
        logic [15:0]        sweeps_used;
        logic               converged;
        logic               alarm;
        logic signed [31:0] point_temp;
    } hcns_out_t;

    localparam logic [1:0] CMD_INIT = 2'd0;
    localparam logic [1:0] CMD_STEP = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [2:0] REG_HALF_GAIN   = 3'd0;
    localparam logic [2:0] REG_SOURCE      = 3'd1;
    localparam logic [2:0] REG_AMBIENT     = 3'd2;
    localparam logic [2:0] REG_TOLERANCE   = 3'd3;
    localparam logic [2:0] REG_MAX_SWEEPS  = 3'd4;
    localparam logic [2:0] REG_THRESHOLD   = 3'd5;
    localparam logic [2:0] REG_ZONE_LOW    = 3'd6;
    localparam logic [2:0] REG_ZONE_HIGH   = 3'd7;

    localparam logic [23:0]        RESET_HALF_GAIN  = 24'd2097152;
    localparam logic signed [31:0] RESET_SOURCE     = 32'sd1057;
    localparam logic signed [31:0] RESET_AMBIENT    = 32'sd7704063;
    localparam logic [23:0]        RESET_TOLERANCE  = 24'd0;
    localparam logic [15:0]        RESET_MAX_SWEEPS = 16'd4096;
    localparam logic signed [31:0] RESET_THRESHOLD  = 32'sd8039937;
    localparam logic [5:0]         RESET_ZONE_LOW   = 6'd24;
    localparam logic [5:0]         RESET_ZONE_HIGH  = 6'd39;

    // clamp a wide signed value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sh007fffffff)
            r = 32'sh7fffffff;
        else if (v < -40'sh0080000000)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/hcns_point_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcns_point_unit
// three-stage crank-nicolson point update: stencil sum, gain product, new value
// ----------------------------------------------------------------------------
module hcns_point_unit
    import hcns_pkg::*;
(
    input  wire logic               clk,
    input  wire logic signed [31:0] prev_l,
    input  wire logic signed [31:0] prev_c,
    input  wire logic signed [31:0] prev_r,
    input  wire logic signed [31:0] now_l,
    input  wire logic signed [31:0] now_c,
    input  wire logic signed [31:0] now_r,
    input  wire logic [23:0]        half_gain,
    input  wire logic signed [31:0] source_increment,
    output logic signed [31:0]      new_temp,
    output logic [32:0]             change
);

    logic signed [35:0] s_full;
    logic signed [31:0] s_sat_reg;
    logic signed [31:0] s_sat_next;
    logic signed [24:0] gain_s;
    logic signed [56:0] prod_next;
    logic signed [56:0] prod_reg;
    logic signed [56:0] prod_rnd;
    logic signed [39:0] new_sum;
    logic signed [39:0] diff;

    // stage 1: both second differences
    assign s_full = 36'(prev_r) + 36'(prev_l) - (36'(prev_c) <<< 1)
                  + 36'(now_r) + 36'(now_l) - (36'(now_c) <<< 1);
    assign s_sat_next = sat32(40'(s_full));

    // stage 2: gain product
    assign gain_s    = $signed({1'b0, half_gain});
    assign prod_next = s_sat_reg * gain_s;

    always_ff @(posedge clk)
    begin
        s_sat_reg <= s_sat_next;
        prod_reg  <= prod_next;
    end

    // stage 3: round half up, add source, clamp
    assign prod_rnd = prod_reg + 57'sd8388608;
    assign new_sum  = 40'(prev_c) + 40'($signed(prod_rnd[56:24])) + 40'(source_increment);
    assign new_temp = sat32(new_sum);
    assign diff     = 40'(new_temp) - 40'(now_c);
    assign change   = diff[39] ? 33'(-diff) : diff[32:0];

endmodule
`default_nettype wire

### rtl/heat_crank_nicolson_solver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// heat_crank_nicolson_solver
// 1-d heat grid in q8.24 relaxed by gauss-seidel crank-nicolson sweeps
// ----------------------------------------------------------------------------
// One command at a time, one status transfer per command. The grid lives in two
// single-port-read synchronous memories (current and previous step). Init writes
// one point at a time. Read fetches one point. A step first copies the current
// grid to the previous-step memory, a read and a write per point, then runs
// sweeps (one read per point through the memory port and a three-stage update
// unit), then an alarm scan; the sweep count is data dependent, bounded by
// max_sweeps, where zero acts as one. The result register lets a finished
// status wait while the next command is taken.
// ----------------------------------------------------------------------------
module heat_crank_nicolson_solver
    import hcns_pkg::*;
#(
    parameter int GRID_POINTS = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire hcns_in_t    in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output hcns_out_t        out_item,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int AW = $clog2(GRID_POINTS);
    localparam logic [AW-1:0] LAST_IDX  = AW'(GRID_POINTS - 1);
    localparam logic [AW-1:0] LAST_INNER = AW'(GRID_POINTS - 2);

    // controller states
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_INIT    = 4'd1;
    localparam logic [3:0] ST_COPY_RD = 4'd2;
    localparam logic [3:0] ST_COPY_WR = 4'd3;
    localparam logic [3:0] ST_LD0     = 4'd4;
    localparam logic [3:0] ST_LD1     = 4'd5;
    localparam logic [3:0] ST_LD2     = 4'd6;
    localparam logic [3:0] ST_PT_S    = 4'd7;
    localparam logic [3:0] ST_PT_MUL  = 4'd8;
    localparam logic [3:0] ST_PT_NEW  = 4'd9;
    localparam logic [3:0] ST_SW_END  = 4'd10;
    localparam logic [3:0] ST_AL_RD   = 4'd11;
    localparam logic [3:0] ST_AL_CK   = 4'd12;
    localparam logic [3:0] ST_RD_RD   = 4'd13;
    localparam logic [3:0] ST_RD_WAIT = 4'd14;
    localparam logic [3:0] ST_RESP    = 4'd15;

    // configuration registers
    logic [23:0]        half_gain_reg;
    logic signed [31:0] source_reg;
    logic signed [31:0] ambient_reg;
    logic [23:0]        tolerance_reg;
    logic [15:0]        max_sweeps_reg;
    logic signed [31:0] threshold_reg;
    logic [5:0]         zone_low_reg;
    logic [5:0]         zone_high_reg;

    // control
    logic [3:0]    state_reg;
    logic [AW-1:0] k_reg;
    logic [5:0]    idx_reg;
    logic [15:0]   sweeps_reg;
    logic [32:0]   worst_reg;
    logic          conv_reg;
    logic          alarm_reg;
    logic [15:0]   steps_reg;
    logic [15:0]   last_sweeps_reg;
    logic          last_conv_reg;
    logic          last_alarm_reg;
    logic signed [31:0] temp_reg;
    logic          out_valid_reg;
    hcns_out_t     out_item_reg;

    // stencil window
    logic signed [31:0] now_l_reg;
    logic signed [31:0] now_c_reg;
    logic signed [31:0] prev_l_reg;
    logic signed [31:0] prev_c_reg;

    // memories
    logic [31:0]            now_mem [GRID_POINTS];
    logic [31:0]            prev_mem [GRID_POINTS];
    logic [GRID_POINTS-1:0] now_vld_reg;
    logic [31:0]            now_rd_reg;
    logic                   now_rd_vld_reg;
    logic [31:0]            prev_rd_reg;
    logic [AW-1:0]          rd_addr;
    logic                   now_we;
    logic [AW-1:0]          now_wa;
    logic [31:0]            now_wd;
    logic                   prev_we;
    logic signed [31:0]     now_rd;
    logic signed [31:0]     prev_rd;

    logic signed [31:0] new_temp;
    logic [32:0]        change;
    logic [15:0]        cap;
    logic [15:0]        sweeps_inc;
    logic               healthy;
    logic               in_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    assign cap        = (max_sweeps_reg == 16'd0) ? 16'd1 : max_sweeps_reg;
    assign sweeps_inc = sweeps_reg + 16'd1;
    assign healthy    = (16'(k_reg) < 16'(zone_low_reg)) || (16'(k_reg) > 16'(zone_high_reg));

    // entries never written read as the reset ambient value
    assign now_rd  = now_rd_vld_reg ? $signed(now_rd_reg) : RESET_AMBIENT;
    assign prev_rd = $signed(prev_rd_reg);

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_gain_reg  <= RESET_HALF_GAIN;
            source_reg     <= RESET_SOURCE;
            ambient_reg    <= RESET_AMBIENT;
            tolerance_reg  <= RESET_TOLERANCE;
            max_sweeps_reg <= RESET_MAX_SWEEPS;
            threshold_reg  <= RESET_THRESHOLD;
            zone_low_reg   <= RESET_ZONE_LOW;
            zone_high_reg  <= RESET_ZONE_HIGH;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HALF_GAIN:  half_gain_reg  <= cfg_data[23:0];
                REG_SOURCE:     source_reg     <= $signed(cfg_data);
                REG_AMBIENT:    ambient_reg    <= $signed(cfg_data);
                REG_TOLERANCE:  tolerance_reg  <= cfg_data[23:0];
                REG_MAX_SWEEPS: max_sweeps_reg <= cfg_data[15:0];
                REG_THRESHOLD:  threshold_reg  <= $signed(cfg_data);
                REG_ZONE_LOW:   zone_low_reg   <= cfg_data[5:0];
                REG_ZONE_HIGH:  zone_high_reg  <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // memory port control
    always_comb
    begin
        rd_addr = k_reg;
        now_we  = 1'b0;
        now_wa  = k_reg;
        now_wd  = ambient_reg;
        prev_we = 1'b0;
        case (state_reg)
            ST_INIT:    now_we = 1'b1;
            ST_COPY_WR: prev_we = 1'b1;
            ST_LD0:     rd_addr = '0;
            ST_LD1:     rd_addr = AW'(1);
            ST_LD2:     rd_addr = AW'(2);
            ST_PT_S,
            ST_PT_MUL:  rd_addr = k_reg + AW'(1);
            ST_PT_NEW:
            begin
                rd_addr = k_reg + AW'(2);
                now_we  = 1'b1;
                now_wd  = new_temp;
            end
            ST_RD_RD:   rd_addr = AW'(idx_reg);
            default: ;
        endcase
    end

    // current grid: data array plus per-entry written flags
    always_ff @(posedge clk)
    begin
        if (now_we)
            now_mem[now_wa] <= now_wd;
        now_rd_reg <= now_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_vld_reg    <= '0;
            now_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (now_we)
                now_vld_reg[now_wa] <= 1'b1;
            now_rd_vld_reg <= now_vld_reg[rd_addr];
        end
    end

    // previous-step grid
    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[k_reg] <= now_rd;
        prev_rd_reg <= prev_mem[rd_addr];
    end

    hcns_point_unit u_point (
        .clk              (clk),
        .prev_l           (prev_l_reg),
        .prev_c           (prev_c_reg),
        .prev_r           (prev_rd),
        .now_l            (now_l_reg),
        .now_c            (now_c_reg),
        .now_r            (now_rd),
        .half_gain        (half_gain_reg),
        .source_increment (source_reg),
        .new_temp         (new_temp),
        .change           (change)
    );

    // window registers are payload only
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_LD1:
            begin
                now_l_reg  <= now_rd;
                prev_l_reg <= prev_rd;
            end
            ST_LD2:
            begin
                now_c_reg  <= now_rd;
                prev_c_reg <= prev_rd;
            end
            ST_PT_NEW:
            begin
                now_l_reg  <= new_temp;
                prev_l_reg <= prev_c_reg;
                now_c_reg  <= now_rd;
                prev_c_reg <= prev_rd;
            end
            default: ;
        endcase
    end

    // command sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            k_reg           <= '0;
            idx_reg         <= '0;
            sweeps_reg      <= '0;
            worst_reg       <= '0;
            conv_reg        <= 1'b0;
            alarm_reg       <= 1'b0;
            steps_reg       <= '0;
            last_sweeps_reg <= '0;
            last_conv_reg   <= 1'b0;
            last_alarm_reg  <= 1'b0;
            temp_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_item_reg    <= '0;
        end
        else
        begin
            // the status state owns the valid flag while it is active
            if (out_valid_reg && out_ready && (state_reg != ST_RESP))
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        k_reg    <= '0;
                        idx_reg  <= in_item.point_index;
                        temp_reg <= '0;
                        case (in_item.cmd)
                            CMD_INIT: state_reg <= ST_INIT;
                            CMD_STEP:
                            begin
                                sweeps_reg <= '0;
                                state_reg  <= ST_COPY_RD;
                            end
                            CMD_READ: state_reg <= ST_RD_RD;
                            default:  state_reg <= ST_RESP;
                        endcase
                    end
                end
                ST_INIT:
                begin
                    if (k_reg == LAST_IDX)
                    begin
                        steps_reg <= '0;
                        state_reg <= ST_RESP;
                    end
                    else
                        k_reg <= k_reg + AW'(1);
                end
                ST_COPY_RD:
                    state_reg <= ST_COPY_WR;
                ST_COPY_WR:
                begin
                    if (k_reg == LAST_IDX)
                        state_reg <= ST_LD0;
                    else
                    begin
                        k_reg     <= k_reg + AW'(1);
                        state_reg <= ST_COPY_RD;
                    end
                end
                ST_LD0:
                begin
                    worst_reg <= '0;
                    state_reg <= ST_LD1;
                end
                ST_LD1:
                    state_reg <= ST_LD2;
                ST_LD2:
                begin
                    k_reg     <= AW'(1);
                    state_reg <= ST_PT_S;
                end
                ST_PT_S:
                    state_reg <= ST_PT_MUL;
                ST_PT_MUL:
                    state_reg <= ST_PT_NEW;
                ST_PT_NEW:
                begin
                    if (change > worst_reg)
                        worst_reg <= change;
                    if (k_reg == LAST_INNER)
                        state_reg <= ST_SW_END;
                    else
                    begin
                        k_reg     <= k_reg + AW'(1);
                        state_reg <= ST_PT_S;
                    end
                end
                ST_SW_END:
                begin
                    sweeps_reg <= sweeps_inc;
                    // tolerance wins over the cap on the same sweep
                    if (worst_reg <= 33'(tolerance_reg))
                    begin
                        conv_reg  <= 1'b1;
                        alarm_reg <= 1'b0;
                        k_reg     <= AW'(1);
                        state_reg <= ST_AL_RD;
                    end
                    else if (sweeps_inc >= cap)
                    begin
                        conv_reg  <= 1'b0;
                        alarm_reg <= 1'b0;
                        k_reg     <= AW'(1);
                        state_reg <= ST_AL_RD;
                    end
                    else
                        state_reg <= ST_LD0;
                end
                ST_AL_RD:
                    state_reg <= ST_AL_CK;
                ST_AL_CK:
                begin
                    if (healthy && (now_rd >= threshold_reg))
                        alarm_reg <= 1'b1;
                    if (k_reg == LAST_IDX)
                    begin
                        last_sweeps_reg <= sweeps_reg;
                        last_conv_reg   <= conv_reg;
                        last_alarm_reg  <= alarm_reg
                                        || (healthy && (now_rd >= threshold_reg));
                        if (steps_reg != 16'hffff)
                            steps_reg <= steps_reg + 16'd1;
                        state_reg <= ST_RESP;
                    end
                    else
                    begin
                        k_reg     <= k_reg + AW'(1);
                        state_reg <= ST_AL_RD;
                    end
                end
                ST_RD_RD:
                    state_reg <= ST_RD_WAIT;
                ST_RD_WAIT:
                begin
                    if (16'(idx_reg) < 16'(GRID_POINTS))
                        temp_reg <= now_rd;
                    state_reg <= ST_RESP;
                end
                ST_RESP:
                begin
                    // result register frees as soon as the waiting transfer goes
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg            <= 1'b1;
                        out_item_reg.step_count  <= steps_reg;
                        out_item_reg.sweeps_used <= last_sweeps_reg;
                        out_item_reg.converged   <= last_conv_reg;
                        out_item_reg.alarm       <= last_alarm_reg;
                        out_item_reg.point_temp  <= temp_reg;
                        state_reg                <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // a taken command always leaves idle on the next cycle
    a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("command accepted but sequencer stayed idle");

    // end points are never rewritten by a sweep
    a_interior_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PT_NEW) |-> (k_reg != '0) && (k_reg <= LAST_INNER))
        else $error("sweep wrote outside the interior");

    // sweep count never passes the cap
    a_sweep_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SW_END) |-> (sweeps_reg < cap))
        else $error("sweep count ran past the cap");

    // converged status implies at least one sweep was run
    a_conv_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_item_reg.converged || (out_item_reg.sweeps_used != 16'd0)))
        else $error("converged reported with no sweeps");
`endif

endmodule
`default_nettype wire

### tb/heat_crank_nicolson_solver_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_crank_nicolson_solver_checker
// watches the command, status and register channels of the heat solver,
// tracks grid and settings, and compares every status transfer in order
// ----------------------------------------------------------------------------
module heat_crank_nicolson_solver_checker
    import hcns_pkg::*;
#(
    parameter int GRID_POINTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  hcns_in_t    in_item,
    input  logic        out_valid,
    input  logic        out_ready,
    input  hcns_out_t   out_item,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending
);

    logic [23:0]        half_gain;
    logic signed [31:0] source_inc;
    logic signed [31:0] ambient;
    logic [23:0]        tolerance;
    logic [15:0]        max_sweeps;
    logic signed [31:0] threshold;
    logic [5:0]         zone_low;
    logic [5:0]         zone_high;

    logic signed [31:0] grid_now [GRID_POINTS];
    logic signed [31:0] grid_prev [GRID_POINTS];
    logic [15:0]        steps_done;
    logic [15:0]        last_sweeps;
    logic               last_conv;
    logic               last_alarm;

    hcns_out_t          status_q [$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // one time step: copy, relax until tolerance or cap, then alarm scan
    task automatic advance_step();
        longint cap, s, p, nv, old, d, worst;
        int     sweeps;
        bit     conv;
        bit     alm;
        cap = (max_sweeps == 0) ? 1 : longint'(max_sweeps);
        for (int j = 0; j < GRID_POINTS; j++)
            grid_prev[j] = grid_now[j];
        sweeps = 0;
        conv = 0;
        do
        begin
            worst = 0;
            for (int j = 1; j < GRID_POINTS - 1; j++)
            begin
                old = longint'(grid_now[j]);
                s = longint'(grid_prev[j+1]) - 2 * longint'(grid_prev[j])
                    + longint'(grid_prev[j-1]) + longint'(grid_now[j+1])
                    - 2 * old + longint'(grid_now[j-1]);
                s = clamp32(s);
                p = (s * longint'({8'd0, half_gain}) + 64'sd8388608) >>> 24;
                nv = clamp32(longint'(grid_prev[j]) + p + longint'(source_inc));
                d = (nv >= old) ? nv - old : old - nv;
                if (d > worst)
                    worst = d;
                grid_now[j] = nv[31:0];
            end
            sweeps++;
            if (worst <= longint'({40'd0, tolerance}))
                conv = 1;
        end
        while (!conv && sweeps < cap);
        alm = 0;
        for (int j = 1; j < GRID_POINTS; j++)
            if ((j < zone_low || j > zone_high) && grid_now[j] >= threshold)
                alm = 1;
        last_sweeps = sweeps[15:0];
        last_conv = conv;
        last_alarm = alm;
        if (steps_done != 16'hffff)
            steps_done++;
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t: status mismatch on %s: got %0d, expected %0d", $realtime, what,
                 got, want);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        half_gain = RESET_HALF_GAIN;
        source_inc = RESET_SOURCE;
        ambient = RESET_AMBIENT;
        tolerance = RESET_TOLERANCE;
        max_sweeps = RESET_MAX_SWEEPS;
        threshold = RESET_THRESHOLD;
        zone_low = RESET_ZONE_LOW;
        zone_high = RESET_ZONE_HIGH;
        for (int j = 0; j < GRID_POINTS; j++)
        begin
            grid_now[j] = RESET_AMBIENT;
            grid_prev[j] = '0;
        end
        steps_done = '0;
        last_sweeps = '0;
        last_conv = 1'b0;
        last_alarm = 1'b0;
    end

    always @(posedge clk)
    begin
        hcns_out_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_HALF_GAIN:  half_gain = cfg_data[23:0];
                    REG_SOURCE:     source_inc = cfg_data;
                    REG_AMBIENT:    ambient = cfg_data;
                    REG_TOLERANCE:  tolerance = cfg_data[23:0];
                    REG_MAX_SWEEPS: max_sweeps = cfg_data[15:0];
                    REG_THRESHOLD:  threshold = cfg_data;
                    REG_ZONE_LOW:   zone_low = cfg_data[5:0];
                    REG_ZONE_HIGH:  zone_high = cfg_data[5:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                want.point_temp = '0;
                case (in_item.cmd)
                    CMD_INIT:
                    begin
                        for (int j = 0; j < GRID_POINTS; j++)
                            grid_now[j] = ambient;
                        steps_done = '0;
                    end
                    CMD_STEP: advance_step();
                    CMD_READ:
                        if (in_item.point_index < GRID_POINTS)
                            want.point_temp = grid_now[in_item.point_index];
                    default: ;
                endcase
                want.step_count = steps_done;
                want.sweeps_used = last_sweeps;
                want.converged = last_conv;
                want.alarm = last_alarm;
                status_q.push_back(want);
            end
            if (out_valid && out_ready)
            begin
                if (status_q.size() == 0)
                begin
                    $display("%0t: status transfer with nothing outstanding", $realtime);
                    errors++;
                end
                else
                begin
                    want = status_q.pop_front();
                    if (out_item.step_count != want.step_count)
                        report("step_count", out_item.step_count, want.step_count);
                    if (out_item.sweeps_used != want.sweeps_used)
                        report("sweeps_used", out_item.sweeps_used, want.sweeps_used);
                    if (out_item.converged != want.converged)
                        report("converged", out_item.converged, want.converged);
                    if (out_item.alarm != want.alarm)
                        report("alarm", out_item.alarm, want.alarm);
                    if (out_item.point_temp != want.point_temp)
                        report("point_temp", out_item.point_temp, want.point_temp);
                end
            end
            pending = status_q.size();
        end
    end

endmodule

### tb/heat_crank_nicolson_solver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heat_crank_nicolson_solver_tb
// drives commands and register writes into the heat solver, with random
// gaps on the command and status channels; the checker beside it predicts
// and compares every status
module heat_crank_nicolson_solver_tb;
    import hcns_pkg::*;

    localparam int         GRID_POINTS = 64;
    localparam logic [1:0] CMD_UNUSED = 2'd3;    // no-op command, status only
    localparam int         STALL_LIMIT = 60000;  // idle cycles before giving up
    localparam int         RANDOM_ITEMS = 115;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    hcns_in_t    in_item;
    logic        out_valid;
    logic        out_ready;
    hcns_out_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          errors;
    int          pending;

    // when set, neither side inserts gaps
    bit          no_idle;

    heat_crank_nicolson_solver #(.GRID_POINTS(GRID_POINTS)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    heat_crank_nicolson_solver_checker #(.GRID_POINTS(GRID_POINTS)) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    // one command transfer; valid only drops when a gap follows
    task automatic send_cmd(input logic [1:0] cmd, input logic [5:0] idx);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item.cmd <= cmd;
        in_item.point_index <= idx;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // drop the command valid, then wait for every outstanding status
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // register write, only issued while the solver is idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [23:0] gain, input logic [31:0] src,
                             input logic [31:0] amb, input logic [23:0] tol,
                             input logic [15:0] cap, input logic [31:0] thr,
                             input logic [5:0] zl, input logic [5:0] zh);
        write_reg(REG_HALF_GAIN, {8'd0, gain});
        write_reg(REG_SOURCE, src);
        write_reg(REG_AMBIENT, amb);
        write_reg(REG_TOLERANCE, {8'd0, tol});
        write_reg(REG_MAX_SWEEPS, {16'd0, cap});
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_ZONE_LOW, {26'd0, zl});
        write_reg(REG_ZONE_HIGH, {26'd0, zh});
    endtask

    // mixed traffic, weighted toward steps and reads of random points
    task automatic random_cmds(input int count);
        int pick;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                no_idle = ~no_idle;
            pick = $urandom_range(0, 99);
            if (pick < 38)
                send_cmd(CMD_STEP, 6'($urandom));
            else if (pick < 85)
                send_cmd(CMD_READ, 6'($urandom));
            else if (pick < 95)
                send_cmd(CMD_INIT, 6'($urandom));
            else
                send_cmd(CMD_UNUSED, 6'($urandom));
        end
    endtask

    // status side: random stall before each transfer
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // watchdog on cycles with no transfer on any channel
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int done;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        no_idle = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset grid readout and the unused command before any step
        send_cmd(CMD_READ, 6'd0);
        send_cmd(CMD_READ, 6'd63);
        send_cmd(CMD_UNUSED, 6'd63);
        drain();

        // default physics with a short cap; tolerance zero never converges early
        write_all(24'd2097152, 32'd1057, 32'd7704063, 24'd0, 16'd4, 32'd8039937,
                  6'd24, 6'd39);
        send_cmd(CMD_STEP, 6'd0);
        send_cmd(CMD_READ, 6'd1);
        send_cmd(CMD_STEP, 6'd0);
        send_cmd(CMD_READ, 6'd32);
        send_cmd(CMD_INIT, 6'd0);
        send_cmd(CMD_READ, 6'd62);
        drain();

        // saturation at the top, full gain, cap of zero acts as one
        write_all(24'hffffff, 32'h7fffffff, 32'h7fffffff, 24'd0, 16'd0, 32'h7fffffff,
                  6'd0, 6'd63);
        send_cmd(CMD_INIT, 6'd0);
        send_cmd(CMD_STEP, 6'd0);
        send_cmd(CMD_STEP, 6'd0);
        send_cmd(CMD_READ, 6'd30);
        drain();

        // saturation at the bottom, threshold at minimum so every healthy point alarms
        write_all(24'd0, 32'h80000000, 32'h80000000, 24'd5, 16'd3, 32'h80000000,
                  6'd63, 6'd0);
        send_cmd(CMD_INIT, 6'd0);
        send_cmd(CMD_STEP, 6'd0);
        send_cmd(CMD_READ, 6'd0);
        drain();

        // largest cap with largest tolerance on a flat grid: one sweep converges
        write_all(24'd3000000, 32'd0, 32'd0, 24'hffffff, 16'hffff, 32'd0, 6'd10, 6'd50);
        send_cmd(CMD_INIT, 6'd0);
        send_cmd(CMD_STEP, 6'd0);
        send_cmd(CMD_STEP, 6'd0);
        send_cmd(CMD_READ, 6'd17);
        drain();

        // random phases, each with fresh settings written while idle
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            logic [31:0] amb;
            logic [31:0] src;
            logic [5:0]  zl;
            amb = $urandom;
            src = ($urandom_range(0, 4) == 0) ? $urandom
                                              : 32'($signed($urandom_range(0, 131072)) - 65536);
            zl = 6'($urandom);
            write_all(24'($urandom),
                      src,
                      amb,
                      ($urandom_range(0, 2) == 0) ? 24'd0 : 24'($urandom_range(0, 1048576)),
                      16'($urandom_range(1, 12)),
                      ($urandom_range(0, 3) == 0) ? $urandom
                                                  : amb + 32'($urandom_range(0, 65536)),
                      zl,
                      zl + 6'($urandom_range(0, 40)));
            send_cmd(CMD_INIT, 6'($urandom));
            random_cmds(22);
            done += 23;
            // at least here the sender holds off until the solver has caught up
            drain();
        end

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### heat_crank_nicolson_solver.f
rtl/hcns_pkg.sv
rtl/hcns_point_unit.sv
rtl/heat_crank_nicolson_solver.sv
tb/heat_crank_nicolson_solver_checker.sv
tb/heat_crank_nicolson_solver_tb.sv
